// ===== design/b64e_pkg.sv =====
`default_nettype none
package b64e_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [6:0] PAD_CHAR = 7'd61;

	// one completed group as handed from the front to the back
	typedef struct packed {
		logic [23:0] grp;
		logic [1:0]  nreal;
		logic        fin;
	} b64e_group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b64e_qstat_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'd65 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'd97 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'd48 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = 7'd43;
		end else begin
			r = 7'd47;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/b64e_front.sv =====
`default_nettype none
module b64e_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_fire,
	input  wire [7:0]             data_byte,
	input  wire                   final_byte,
	output logic                  push,
	output b64e_pkg::b64e_group_t push_grp
);
	import b64e_pkg::*;

	logic [7:0] held_q [2];
	logic [1:0] cnt_q;
	logic       completes;

	// a count of three is never reached, the high bit alone means two held
	assign completes = final_byte | cnt_q[1];
	assign push      = in_fire & completes;

	always_comb begin
		push_grp.fin = final_byte;
		if (cnt_q[1]) begin
			push_grp.grp   = {held_q[0], held_q[1], data_byte};
			push_grp.nreal = 2'd3;
		end else if (cnt_q[0]) begin
			push_grp.grp   = {held_q[0], data_byte, 8'd0};
			push_grp.nreal = 2'd2;
		end else begin
			push_grp.grp   = {data_byte, 16'd0};
			push_grp.nreal = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire) begin
			if (completes) begin
				cnt_q <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !completes) begin
			held_q[cnt_q[0]] <= data_byte;
		end
	end

endmodule
`default_nettype wire

// ===== design/b64e_queue.sv =====
`default_nettype none
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  b64e_pkg::b64e_group_t push_grp,
	input  wire                   pop,
	output b64e_pkg::b64e_group_t pop_grp,
	output b64e_pkg::b64e_qstat_t stat
);
	import b64e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64e_group_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign pop_grp    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_grp;
		end
	end

endmodule
`default_nettype wire

// ===== design/b64e_back.sv =====
`default_nettype none
module b64e_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  b64e_pkg::b64e_group_t pop_grp,
	input  b64e_pkg::b64e_qstat_t stat,
	output logic                  pop,
	output logic                  m_valid,
	input  wire                   m_ready,
	output logic [6:0]            symbol,
	output logic                  run_last,
	output logic                  message_end
);
	import b64e_pkg::*;

	b64e_group_t cur_q;
	logic [1:0]  idx_q;
	logic        busy_q;
	logic        valid_q;
	logic [6:0]  sym_q;
	logic        last_q;
	logic        end_q;
	logic        out_free;
	logic        step;
	logic [5:0]  sextet;
	logic [6:0]  chr;

	assign out_free = ~valid_q | m_ready;
	assign step     = busy_q & out_free;
	// next group loads as the current one hands over its fourth character
	assign pop      = ~stat.empty & (~busy_q | (step & (idx_q == 2'd3)));

	always_comb begin
		case (idx_q)
			2'd0:    sextet = cur_q.grp[23:18];
			2'd1:    sextet = cur_q.grp[17:12];
			2'd2:    sextet = cur_q.grp[11:6];
			default: sextet = cur_q.grp[5:0];
		endcase
		chr = b64_char(sextet);
		if (idx_q == 2'd2 && cur_q.nreal < 2'd2) begin
			chr = PAD_CHAR;
		end else if (idx_q == 2'd3 && cur_q.nreal < 2'd3) begin
			chr = PAD_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				valid_q <= 1'b1;
				idx_q   <= idx_q + 2'd1;
			end else if (m_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (step && idx_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_grp;
		end
		if (step) begin
			sym_q  <= chr;
			last_q <= (idx_q == 2'd3);
			end_q  <= (idx_q == 2'd3) & cur_q.fin;
		end
	end

	assign m_valid     = valid_q;
	assign symbol      = sym_q;
	assign run_last    = last_q;
	assign message_end = end_q;

endmodule
`default_nettype wire

// ===== design/base64_stream_encoder_top.sv =====
// a closing byte's group passes the queue, cur_q and sym_q before its first character shows
// throughput: one character per cycle while m_tready holds and groups are queued, four
//   characters per group; the character serializer in the back end sets that rate
// a byte that does not close a group is held in the front end and produces no output
// reset: arst_n clears held count, queue pointers and output valid at once; no clearing pass
`default_nettype none
module base64_stream_encoder_top #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,  // [7:0] data_byte
	input  wire        s_tlast,  // final_byte
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,  // [6:0] symbol, [7] zero
	output logic       m_tlast,  // run_last
	output logic [0:0] m_tuser   // [0] message_end
);
	import b64e_pkg::*;

	b64e_group_t push_grp;
	b64e_group_t pop_grp;
	b64e_qstat_t stat;
	logic        push;
	logic        pop;
	logic        in_fire;
	logic [6:0]  symbol;
	logic        msg_end;

	assign s_tready = ~stat.full;
	assign in_fire  = s_tvalid & s_tready;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.data_byte  (s_tdata),
		.final_byte (s_tlast),
		.push       (push),
		.push_grp   (push_grp)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.pop_grp  (pop_grp),
		.stat     (stat)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_grp     (pop_grp),
		.stat        (stat),
		.pop         (pop),
		.m_valid     (m_tvalid),
		.m_ready     (m_tready),
		.symbol      (symbol),
		.run_last    (m_tlast),
		.message_end (msg_end)
	);

	assign m_tdata    = {1'b0, symbol};
	assign m_tuser[0] = msg_end;

	// a completed group must never meet a full queue
	a_no_lost_group: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("group pushed into full queue");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue full and empty at once");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("message end off a run boundary");

	// a waiting group stays queued until the serializer pops it
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!stat.empty && !pop) |=> !stat.empty)
		else $error("queued group vanished without a pop");

endmodule
`default_nettype wire

// ===== tb/base64_stream_encoder_top_tb.sv =====
module base64_stream_encoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64e_pkg::*;

	localparam int RAND_COUNT   = 200;
	localparam int LONG_HOLD    = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DIRECTED_N   = 20;
	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] symbol;
		logic       run_last;
		logic       msg_end;
	} char_exp_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic        typed;
		logic [31:0] text;
	} stim_row_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tready = 1'b0;
	wire        s_tready;
	wire        m_tvalid;
	wire  [7:0] m_tdata;
	wire        m_tlast;
	wire  [0:0] m_tuser;

	base64_stream_encoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// typed text is only given on the byte that closes a group
	stim_row_t directed_rows [0:DIRECTED_N-1] = '{
		'{8'h00, 1'b1, 1'b1, "AA=="},
		'{8'hFF, 1'b1, 1'b1, "/w=="},
		'{8'h01, 1'b1, 1'b1, "AQ=="},
		'{8'h80, 1'b1, 1'b1, "gA=="},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b1, 1'b1, "AAA="},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, "//8="},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b1, "AAAA"},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, "////"},
		'{8'h4D, 1'b0, 1'b0, 32'h0},
		'{8'h61, 1'b0, 1'b0, 32'h0},
		'{8'h6E, 1'b1, 1'b1, "TWFu"},
		'{8'hFB, 1'b0, 1'b0, 32'h0},
		'{8'hEF, 1'b0, 1'b0, 32'h0},
		'{8'hBE, 1'b0, 1'b1, "++++"}
	};

	char_exp_t pending_chars[$];
	logic [7:0] held_a, held_b;
	logic [1:0] held_n = 2'd0;

	int errors      = 0;
	int bytes_sent  = 0;
	int msgs_sent   = 0;
	int chars_seen  = 0;
	int pads_seen   = 0;
	int in_stalls   = 0;
	int quiet       = 0;
	int burst_left  = 0;
	logic long_hold_req = 1'b0;

	function automatic logic [6:0] alpha(input logic [5:0] idx);
		return ALPHABET[(63 - idx) * 8 +: 7];
	endfunction

	// returns how many characters the byte releases, packed first character highest
	function automatic int encode_byte(input logic [7:0] d, input logic fin,
			output logic [27:0] syms);
		logic [23:0] grp;
		logic [1:0]  nreal;
		syms = '0;
		if (held_n < 2'd2 && !fin) begin
			if (held_n == 2'd0) held_a = d;
			else held_b = d;
			held_n = held_n + 2'd1;
			return 0;
		end
		case (held_n)
			2'd0: grp = {d, 16'h0000};
			2'd1: grp = {held_a, d, 8'h00};
			default: grp = {held_a, held_b, d};
		endcase
		nreal = (held_n == 2'd0) ? 2'd1 : (held_n == 2'd1) ? 2'd2 : 2'd3;
		syms[27:21] = alpha(grp[23:18]);
		syms[20:14] = alpha(grp[17:12]);
		syms[13:7]  = (nreal > 2'd1) ? alpha(grp[11:6]) : PAD_CHAR;
		syms[6:0]   = (nreal > 2'd2) ? alpha(grp[5:0]) : PAD_CHAR;
		held_n = 2'd0;
		return 4;
	endfunction

	task automatic send_byte(input logic [7:0] d, input logic fin, input logic typed,
			input logic [31:0] text);
		int gap;
		int n;
		logic [27:0] syms;
		char_exp_t ce;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (fin) msgs_sent++;
		n = encode_byte(d, fin, syms);
		for (int j = 0; j < n; j++) begin
			ce.symbol   = typed ? text[(3 - j) * 8 +: 7] : syms[(3 - j) * 7 +: 7];
			ce.run_last = (j == 3);
			ce.msg_end  = (j == 3) && fin;
			pending_chars.push_back(ce);
		end
	endtask

	// receiver: switches between stall patterns, plus one long hold-off on request
	int   rx_mode = 0;
	int   rx_left = 0;
	int   rx_phase = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (long_hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(8, 48);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_phase % 4 != 3);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin : char_check
		char_exp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			chars_seen++;
			if (m_tdata[6:0] == PAD_CHAR) pads_seen++;
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected character transaction, expected none, got %h last %b end %b",
					$time, m_tdata[6:0], m_tlast, m_tuser[0]);
			end else begin
				e = pending_chars.pop_front();
				if (m_tdata[6:0] !== e.symbol || m_tlast !== e.run_last ||
						m_tuser[0] !== e.msg_end) begin
					errors++;
					$display("%0t: mismatch, expected %h last %b end %b, got %h last %b end %b",
						$time, e.symbol, e.run_last, e.msg_end,
						m_tdata[6:0], m_tlast, m_tuser[0]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_tready) in_stalls++;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("base64_stream_encoder_top test failed");
				$finish;
			end
		end
	end

	initial begin
		int len;
		logic hold_asked;
		logic drained;
		hold_asked = 1'b0;
		drained    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_byte(directed_rows[i].data, directed_rows[i].fin,
				directed_rows[i].typed, directed_rows[i].text);

		while (bytes_sent < DIRECTED_N + RAND_COUNT) begin
			if (!hold_asked && bytes_sent >= 60) begin
				// keep offering through the hold-off so the input backs up
				hold_asked = 1'b1;
				long_hold_req <= 1'b1;
				burst_left = 80;
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
			for (int k = 1; k <= len; k++)
				send_byte(8'($urandom_range(0, 255)), k == len, 1'b0, 32'h0);
			if (!drained && bytes_sent >= 150) begin
				drained = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_chars.size() != 0);
				burst_left = 0;
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
		repeat (8) @(posedge clk);
		if (pending_chars.size() != 0) begin
			errors++;
			$display("%0t: %0d characters never arrived", $time, pending_chars.size());
		end
		$display("encoded %0d messages of %0d bytes into %0d characters, %0d of them pads",
			msgs_sent, bytes_sent, chars_seen, pads_seen);
		$display("input held back for %0d cycles, %0d errors", in_stalls, errors);
		if (errors == 0)
			$display("base64_stream_encoder_top test passed");
		else
			$display("base64_stream_encoder_top test failed");
		$finish;
	end

endmodule
